### rtl/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg: shared types and constants for the radix-to-text converter
// Holds field widths, configuration register indexes, character codes and
// the job record that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package srt_pkg;

  // Field and port widths.
  localparam int NUM_W      = 32;
  localparam int CHAR_W     = 8;
  localparam int RADIX_W    = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_A = 3'd1;

  // Symbols per alphabet register.
  localparam int SYMS_PER_REG = CFG_DATA_W / CHAR_W;

  // Character codes and limits used by alphabet checking and output.
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_LOW   = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_HIGH  = 8'd127;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'd0;

  // Smallest usable radix.
  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;

  // Digit stack: base 2 gives at most 32 digits for a 32-bit magnitude.
  localparam int STACK_DEPTH = 32;
  localparam int STACK_IW    = $clog2(STACK_DEPTH);
  localparam int ND_W        = STACK_IW + 1;
  localparam int DIGIT_W     = 5;

  // Long division takes this many dividend bits per cycle.
  localparam int CHUNK_W     = 8;
  localparam int CHUNKS      = NUM_W / CHUNK_W;
  localparam int CHUNK_CNT_W = $clog2(CHUNKS);
  localparam logic [CHUNK_CNT_W-1:0] CHUNK_LAST = CHUNK_CNT_W'(CHUNKS - 1);

  // Queue between front and back end.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_IW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = QUEUE_IW + 1;

  typedef logic [CHAR_W-1:0] char_t;

  // One classified number waiting for conversion.
  typedef struct packed {
    logic [NUM_W-1:0] mag;
    logic             neg;
    logic             bad;
  } job_t;

  // Back end sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_SIGN = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_BAD  = 5'b10000
  } back_state_e;

endpackage

### rtl/srt_cfg.sv
// ----------------------------------------------------------------------------
// srt_cfg: configuration registers and alphabet checker
// Stores the radix and the symbol bytes. After every write a sequencer walks
// the symbols one per cycle and decides whether the alphabet is usable.
// ----------------------------------------------------------------------------
module srt_cfg #(
  parameter int MAX_DIGITS = 32,
  localparam int SYM_IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [srt_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [srt_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output logic [srt_pkg::RADIX_W-1:0]       radix_o,
  output srt_pkg::char_t                    sym_o [MAX_DIGITS],
  output logic                              alpha_ok_o,
  output logic                              busy_o
);

  logic [srt_pkg::RADIX_W-1:0] radix_q;
  srt_pkg::char_t              sym_q [MAX_DIGITS];
  logic                        busy_q;
  logic                        ok_q;
  logic [SYM_IW-1:0]           idx_q;

  srt_pkg::char_t sym_cur;
  logic           in_use;
  logic           fail;

  // Radix register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= '0;
    end else if (cfg_we_i && cfg_idx_i == srt_pkg::CFG_RADIX) begin
      radix_q <= cfg_wdata_i[srt_pkg::RADIX_W-1:0];
    end
  end

  // Symbol bytes; only the symbols that can ever be in use are kept.
  for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_sym
    localparam int REG = k / srt_pkg::SYMS_PER_REG;
    localparam int BYT = k % srt_pkg::SYMS_PER_REG;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sym_q[k] <= '0;
      end else if (cfg_we_i &&
                   cfg_idx_i == srt_pkg::CFG_DIGITS_A + srt_pkg::CFG_IDX_W'(REG)) begin
        sym_q[k] <= cfg_wdata_i[BYT*srt_pkg::CHAR_W +: srt_pkg::CHAR_W];
      end
    end
  end

  // Check of the symbol under the walk pointer against the rules and against
  // every later symbol in use; at slot zero the radix range is checked too.
  always_comb begin
    sym_cur = sym_q[idx_q];
    in_use  = int'(idx_q) < int'(radix_q);
    fail    = 1'b0;
    if (in_use) begin
      if (sym_cur < srt_pkg::CHAR_LOW || sym_cur > srt_pkg::CHAR_HIGH ||
          sym_cur == srt_pkg::CHAR_MINUS || sym_cur == srt_pkg::CHAR_PLUS) begin
        fail = 1'b1;
      end
      for (int j = 0; j < MAX_DIGITS; j++) begin
        if (j > int'(idx_q) && j < int'(radix_q) && sym_q[j] == sym_cur) begin
          fail = 1'b1;
        end
      end
    end
    if (idx_q == '0 && (radix_q < srt_pkg::RADIX_MIN ||
                        radix_q > srt_pkg::RADIX_W'(MAX_DIGITS))) begin
      fail = 1'b1;
    end
  end

  // Walk sequencer: restarts on every write and runs over all symbol slots.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ok_q   <= 1'b0;
      idx_q  <= '0;
    end else if (cfg_we_i) begin
      busy_q <= 1'b1;
      ok_q   <= 1'b1;
      idx_q  <= '0;
    end else if (busy_q) begin
      ok_q <= ok_q & ~fail;
      if (idx_q == SYM_IW'(MAX_DIGITS - 1)) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  assign radix_o    = radix_q;
  assign sym_o      = sym_q;
  assign alpha_ok_o = ok_q;
  assign busy_o     = busy_q;

endmodule

### rtl/srt_front.sv
// ----------------------------------------------------------------------------
// srt_front: input acceptance and classification
// Takes a number, splits it into sign and magnitude and tags it with the
// alphabet verdict before it enters the job queue.
// ----------------------------------------------------------------------------
module srt_front (
  input  logic                           push,
  output logic                           full,
  input  logic signed [srt_pkg::NUM_W-1:0] number_i,
  input  logic                           cfg_busy_i,
  input  logic                           alpha_ok_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output srt_pkg::job_t                  q_data_o
);

  logic [srt_pkg::NUM_W-1:0] raw;

  // Hold off input while the queue is full or the alphabet is being checked.
  assign full     = q_full_i | cfg_busy_i;
  assign q_push_o = push & ~full;

  // Magnitude in 32 unsigned bits; the most negative value maps onto itself.
  always_comb begin
    raw           = number_i;
    q_data_o.neg  = raw[srt_pkg::NUM_W-1];
    q_data_o.mag  = raw[srt_pkg::NUM_W-1] ? (~raw + 1'b1) : raw;
    q_data_o.bad  = ~alpha_ok_i;
  end

endmodule

### rtl/srt_queue.sv
// ----------------------------------------------------------------------------
// srt_queue: short job queue between front and back end
// A small register FIFO that lets the front end take new numbers while the
// back end is still converting.
// ----------------------------------------------------------------------------
module srt_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  srt_pkg::job_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output srt_pkg::job_t rdata_o,
  output logic          empty_o
);

  srt_pkg::job_t                   data_q [srt_pkg::QUEUE_DEPTH];
  logic [srt_pkg::QUEUE_IW-1:0]    wr_q;
  logic [srt_pkg::QUEUE_IW-1:0]    rd_q;
  logic [srt_pkg::QUEUE_CW-1:0]    cnt_q;
  logic                            do_push;
  logic                            do_pop;

  assign full_o  = cnt_q == srt_pkg::QUEUE_CW'(srt_pkg::QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = data_q[rd_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wr_q] <= wdata_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### rtl/srt_back.sv
// ----------------------------------------------------------------------------
// srt_back: digit generation and character output
// Divides the magnitude by the radix, eight dividend bits per cycle, pushes
// each remainder onto a digit stack and then emits sign and symbols from the
// top of the stack through an output register.
// ----------------------------------------------------------------------------
module srt_back #(
  parameter int MAX_DIGITS = 32,
  localparam int SYM_IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  srt_pkg::job_t               q_data_i,
  output logic                        q_pop_o,
  input  logic [srt_pkg::RADIX_W-1:0] radix_i,
  input  srt_pkg::char_t              sym_i [MAX_DIGITS],
  output logic                        empty,
  input  logic                        pop,
  output srt_pkg::char_t              character_o,
  output logic                        last_o,
  output logic                        bad_alphabet_o
);

  srt_pkg::back_state_e                state_q, state_d;
  logic [srt_pkg::NUM_W-1:0]           work_q, work_d;
  logic [srt_pkg::DIGIT_W-1:0]         rem_q, rem_d;
  logic [srt_pkg::CHUNK_CNT_W-1:0]     chunk_q, chunk_d;
  logic [srt_pkg::ND_W-1:0]            nd_q, nd_d;
  logic                                neg_q, neg_d;
  logic [srt_pkg::DIGIT_W-1:0]         stack_q [srt_pkg::STACK_DEPTH];
  logic                                ovalid_q, ovalid_d;
  srt_pkg::char_t                      ochar_q, ochar_d;
  logic                                olast_q, olast_d;
  logic                                obad_q, obad_d;

  logic                                stack_we;
  logic                                out_we;
  logic                                out_ld;
  logic [srt_pkg::CHUNK_W-1:0]         qbits;
  logic [srt_pkg::DIGIT_W:0]           r_sh;
  logic [srt_pkg::DIGIT_W-1:0]         r_cur;
  logic [srt_pkg::NUM_W-1:0]           work_next;
  logic [srt_pkg::ND_W-1:0]            nd_m1;
  logic [srt_pkg::DIGIT_W-1:0]         top_digit;
  srt_pkg::char_t                      top_char;

  // One chunk of restoring long division: eight quotient bits per cycle.
  always_comb begin
    r_cur = rem_q;
    qbits = '0;
    r_sh  = '0;
    for (int k = srt_pkg::CHUNK_W - 1; k >= 0; k--) begin
      r_sh = {r_cur, work_q[srt_pkg::NUM_W - srt_pkg::CHUNK_W + k]};
      if (r_sh >= radix_i) begin
        qbits[k] = 1'b1;
        r_sh     = r_sh - radix_i;
      end
      r_cur = r_sh[srt_pkg::DIGIT_W-1:0];
    end
    work_next = {work_q[srt_pkg::NUM_W-srt_pkg::CHUNK_W-1:0], qbits};
  end

  // Symbol for the digit on top of the stack.
  assign nd_m1     = nd_q - 1'b1;
  assign top_digit = stack_q[nd_m1[srt_pkg::STACK_IW-1:0]];
  assign top_char  = sym_i[top_digit[SYM_IW-1:0]];

  // The output register takes a new character when empty or being drained.
  assign out_ld = ~ovalid_q | pop;

  // Sequencer: fetch, divide, sign, emit digits, or report a bad alphabet.
  always_comb begin
    state_d  = state_q;
    work_d   = work_q;
    rem_d    = rem_q;
    chunk_d  = chunk_q;
    nd_d     = nd_q;
    neg_d    = neg_q;
    q_pop_o  = 1'b0;
    stack_we = 1'b0;
    out_we   = 1'b0;
    ochar_d  = ochar_q;
    olast_d  = olast_q;
    obad_d   = obad_q;
    unique case (state_q)
      srt_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (q_data_i.bad) begin
            state_d = srt_pkg::ST_BAD;
          end else begin
            work_d  = q_data_i.mag;
            rem_d   = '0;
            chunk_d = '0;
            nd_d    = '0;
            neg_d   = q_data_i.neg;
            state_d = srt_pkg::ST_DIV;
          end
        end
      end
      srt_pkg::ST_DIV: begin
        work_d  = work_next;
        rem_d   = r_cur;
        chunk_d = chunk_q + 1'b1;
        if (chunk_q == srt_pkg::CHUNK_LAST) begin
          stack_we = 1'b1;
          rem_d    = '0;
          nd_d     = nd_q + 1'b1;
          if (work_next == '0 ||
              nd_q == srt_pkg::ND_W'(srt_pkg::STACK_DEPTH - 1)) begin
            state_d = neg_q ? srt_pkg::ST_SIGN : srt_pkg::ST_EMIT;
          end
        end
      end
      srt_pkg::ST_SIGN: begin
        if (out_ld) begin
          out_we  = 1'b1;
          ochar_d = srt_pkg::CHAR_MINUS;
          olast_d = 1'b0;
          obad_d  = 1'b0;
          state_d = srt_pkg::ST_EMIT;
        end
      end
      srt_pkg::ST_EMIT: begin
        if (out_ld) begin
          out_we  = 1'b1;
          ochar_d = top_char;
          olast_d = nd_q == srt_pkg::ND_W'(1);
          obad_d  = 1'b0;
          nd_d    = nd_m1;
          if (nd_q == srt_pkg::ND_W'(1)) begin
            state_d = srt_pkg::ST_IDLE;
          end
        end
      end
      srt_pkg::ST_BAD: begin
        if (out_ld) begin
          out_we  = 1'b1;
          ochar_d = srt_pkg::CHAR_NONE;
          olast_d = 1'b1;
          obad_d  = 1'b1;
          state_d = srt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = srt_pkg::ST_IDLE;
      end
    endcase
    ovalid_d = out_we | (ovalid_q & ~pop);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= srt_pkg::ST_IDLE;
      chunk_q  <= '0;
      nd_q     <= '0;
      neg_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      chunk_q  <= chunk_d;
      nd_q     <= nd_d;
      neg_q    <= neg_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Datapath registers and digit stack.
  always_ff @(posedge clk_i) begin
    work_q  <= work_d;
    rem_q   <= rem_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
    obad_q  <= obad_d;
    if (stack_we) begin
      stack_q[nd_q[srt_pkg::STACK_IW-1:0]] <= r_cur;
    end
  end

  assign empty          = ~ovalid_q;
  assign character_o    = ochar_q;
  assign last_o         = olast_q;
  assign bad_alphabet_o = obad_q;

endmodule

### rtl/signed_radix_to_text.sv
// ----------------------------------------------------------------------------
// signed_radix_to_text: signed 32-bit number to text in a configured radix
// Top level: configuration and alphabet check, front end, job queue and
// digit back end.
// ----------------------------------------------------------------------------
// Each number pushed in comes out as a run of characters, most significant
// digit first, with a leading minus sign for negatives and last set on the
// final character; a bad alphabet yields one character of zero flagged
// bad_alphabet and last. A number first leaves the job queue, then each
// digit is found in the long divider (eight quotient bits per cycle against
// the radix) and pushed onto the digit stack, and then sign and digits go
// out through the output register as they are popped. The two-entry queue
// lets new numbers be accepted while one is converting. After every
// configuration write the input reports full while the alphabet checker
// walks the symbols one per cycle.
module signed_radix_to_text #(
  parameter int MAX_DIGITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic signed [srt_pkg::NUM_W-1:0]    number_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [srt_pkg::CHAR_W-1:0]          character_o,
  output logic                                last_o,
  output logic                                bad_alphabet_o,
  input  logic                                cfg_we_i,
  input  logic [srt_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [srt_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  logic [srt_pkg::RADIX_W-1:0] radix;
  srt_pkg::char_t              sym [MAX_DIGITS];
  logic                        alpha_ok;
  logic                        cfg_busy;
  logic                        q_full;
  logic                        q_push;
  logic                        q_pop;
  logic                        q_empty;
  srt_pkg::job_t               q_wdata;
  srt_pkg::job_t               q_rdata;

  // Configuration registers and alphabet check.
  srt_cfg #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .radix_o     (radix),
    .sym_o       (sym),
    .alpha_ok_o  (alpha_ok),
    .busy_o      (cfg_busy)
  );

  // Input transfer and classification.
  srt_front u_front (
    .push       (push),
    .full       (full),
    .number_i   (number_i),
    .cfg_busy_i (cfg_busy),
    .alpha_ok_i (alpha_ok),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  // Job queue.
  srt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  // Division and character output.
  srt_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_data_i       (q_rdata),
    .q_pop_o        (q_pop),
    .radix_i        (radix),
    .sym_i          (sym),
    .empty          (empty),
    .pop            (pop),
    .character_o    (character_o),
    .last_o         (last_o),
    .bad_alphabet_o (bad_alphabet_o)
  );

endmodule

### tb/signed_radix_to_text_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_radix_to_text_checker: scoreboard for the radix-to-text converter
// Tracks configuration writes, spells every accepted number into the
// characters it should produce and compares each character transfer on the
// output side against the oldest spelled character, field by field.
// ----------------------------------------------------------------------------
module signed_radix_to_text_checker
  import srt_pkg::*;
#(
  parameter int MAX_DIGITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic                  full_i,
  input  logic [NUM_W-1:0]      number_i,
  input  logic                  empty_i,
  input  logic                  pop_i,
  input  char_t                 character_i,
  input  logic                  last_i,
  input  logic                  bad_alphabet_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int unsigned           pending_o,
  output int unsigned           fail_count_o
);

  localparam int NUM_BANKS   = 4;
  localparam int SYM_SLOTS   = NUM_BANKS * SYMS_PER_REG;
  localparam int REPORT_MAX  = 10;

  // One character as it should leave the block.
  typedef struct packed {
    char_t ch;
    logic  last;
    logic  bad;
  } text_char_t;

  text_char_t             spelled_q[$];
  logic [RADIX_W-1:0]     radix_r;
  logic [CFG_DATA_W-1:0]  sym_bank [NUM_BANKS];

  // Symbol idx of the configured alphabet.
  function automatic char_t symbol_of(int unsigned idx);
    int unsigned k;
    k = idx % SYM_SLOTS;
    return sym_bank[k / SYMS_PER_REG][(k % SYMS_PER_REG) * CHAR_W +: CHAR_W];
  endfunction

  // The alphabet in use must be in range, printable, sign free and unique.
  function automatic bit alphabet_ok();
    int unsigned n;
    int unsigned i;
    int unsigned j;
    char_t       s;
    n = radix_r;
    if (n < RADIX_MIN || n > MAX_DIGITS || n > SYM_SLOTS) return 1'b0;
    for (i = 0; i < n; i++) begin
      s = symbol_of(i);
      if (s == CHAR_MINUS || s == CHAR_PLUS || s < CHAR_LOW || s > CHAR_HIGH) return 1'b0;
      for (j = i + 1; j < n; j++) begin
        if (symbol_of(j) == s) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Appends the characters of one number, sign first, top digit first.
  function automatic void spell_number(logic [NUM_W-1:0] raw);
    int unsigned       digit_buf [STACK_DEPTH];
    int unsigned       nd;
    logic [NUM_W-1:0]  mag32;
    longint unsigned   mag;
    longint unsigned   base;
    logic              neg;
    if (!alphabet_ok()) begin
      spelled_q.push_back('{ch: CHAR_NONE, last: 1'b1, bad: 1'b1});
      return;
    end
    neg   = raw[NUM_W-1];
    mag32 = neg ? -raw : raw;
    mag   = mag32;
    base  = radix_r;
    nd    = 0;
    do begin
      digit_buf[nd] = int'(mag % base);
      mag = mag / base;
      nd++;
    end while (mag != 0 && nd < STACK_DEPTH);
    if (neg) spelled_q.push_back('{ch: CHAR_MINUS, last: 1'b0, bad: 1'b0});
    while (nd > 0) begin
      nd--;
      spelled_q.push_back('{ch: symbol_of(digit_buf[nd]), last: (nd == 0), bad: 1'b0});
    end
  endfunction

  // Output side first, so a character never matches a number pushed at
  // the same edge; then input transfers and configuration writes.
  always @(posedge clk_i or negedge rst_ni) begin
    text_char_t got;
    text_char_t want;
    if (!rst_ni) begin
      radix_r = '0;
      for (int k = 0; k < NUM_BANKS; k++) sym_bank[k] = '0;
      spelled_q.delete();
    end else begin
      if (pop_i && !empty_i) begin
        got = '{ch: character_i, last: last_i, bad: bad_alphabet_i};
        if (spelled_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= REPORT_MAX)
            $display("%0t: unexpected character %h last %b bad_alphabet %b",
                     $time, got.ch, got.last, got.bad);
        end else begin
          want = spelled_q.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= REPORT_MAX)
              $display("%0t: mismatch character exp %h got %h, last exp %b got %b, %s",
                       $time, want.ch, got.ch, want.last, got.last,
                       $sformatf("bad_alphabet exp %b got %b", want.bad, got.bad));
          end
        end
      end
      if (push_i && !full_i) spell_number(number_i);
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_RADIX) begin
          radix_r = cfg_wdata_i[RADIX_W-1:0];
        end else if (cfg_idx_i >= CFG_DIGITS_A &&
                     int'(cfg_idx_i) < int'(CFG_DIGITS_A) + NUM_BANKS) begin
          sym_bank[cfg_idx_i - CFG_DIGITS_A] = cfg_wdata_i;
        end
      end
    end
    pending_o = spelled_q.size();
  end

endmodule

### tb/tb_signed_radix_to_text.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_radix_to_text: testbench top for the radix-to-text converter
// Drives configuration writes and numbers with random gaps on both sides,
// first a directed set of alphabets and values, then random alphabets, bad
// alphabets and numbers. The checker beside the block scores every transfer.
// ----------------------------------------------------------------------------
module tb_signed_radix_to_text;
  import srt_pkg::*;

  localparam int              MAX_DIGITS    = 32;
  localparam int              CLK_HALF      = 6;
  localparam int              RESET_CYCLES  = 4;
  localparam int              RANDOM_ITEMS  = 500;
  localparam int              SETTLE_CYCLES = 200;
  localparam int              NUM_BANKS     = 4;
  localparam int              SYM_SLOTS     = NUM_BANKS * SYMS_PER_REG;
  localparam int              POOL_SIZE     = 94;
  // About 520 numbers of up to 33 characters, each character waiting out
  // the longest output stall, plus each conversion, taken several times.
  localparam longint unsigned CYCLE_LIMIT   = 4_000_000;

  // Ways to break an alphabet.
  typedef enum int {
    BAD_RADIX_LOW,
    BAD_RADIX_HIGH,
    BAD_PLUS,
    BAD_MINUS,
    BAD_CONTROL,
    BAD_HIGH_BIT,
    BAD_REPEAT
  } flaw_e;

  logic                          clk_i;
  logic                          rst_ni    = 1'b0;
  logic                          push      = 1'b0;
  logic                          full;
  logic signed [NUM_W-1:0]       number    = '0;
  logic                          empty;
  logic                          pop       = 1'b0;
  char_t                         character;
  logic                          last;
  logic                          bad_alphabet;
  logic                          cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_idx   = '0;
  logic [CFG_DATA_W-1:0]         cfg_wdata = '0;

  int unsigned                   pending;
  int unsigned                   fail_count;
  longint unsigned               cycle_cnt = 0;
  int unsigned                   sent      = 0;
  int unsigned                   cur_radix = 0;
  int unsigned                   pop_hold  = 0;
  bit                            pop_steady  = 1'b0;
  bit                            send_steady = 1'b0;
  char_t                         alpha_buf [SYM_SLOTS];

  signed_radix_to_text #(
    .MAX_DIGITS     (MAX_DIGITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .number_i       (number),
    .empty          (empty),
    .pop            (pop),
    .character_o    (character),
    .last_o         (last),
    .bad_alphabet_o (bad_alphabet),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata)
  );

  signed_radix_to_text_checker #(
    .MAX_DIGITS     (MAX_DIGITS)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_i         (full),
    .number_i       (number),
    .empty_i        (empty),
    .pop_i          (pop),
    .character_i    (character),
    .last_i         (last),
    .bad_alphabet_i (bad_alphabet),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int unsigned idle_len(bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // Output side: pop with random stalls, with stretches of no stalls.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (pop_hold != 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 2) == 0) pop_hold = idle_len(pop_steady);
    end
    if ($urandom_range(0, 249) == 0) pop_steady = !pop_steady;
  end

  // Symbols past the alphabet are ignored, so they get any byte at all.
  function automatic void fill_tail(int unsigned from);
    for (int unsigned i = from; i < SYM_SLOTS; i++) alpha_buf[i] = CHAR_W'($urandom);
  endfunction

  function automatic void load_text(string s);
    for (int i = 0; i < s.len(); i++) alpha_buf[i] = s[i];
    fill_tail(s.len());
  endfunction

  // Random valid alphabet of rdx distinct printable symbols.
  function automatic void random_alphabet(int unsigned rdx);
    char_t       pool [POOL_SIZE];
    char_t       tmp;
    int unsigned k;
    int unsigned j;
    k = 0;
    for (int c = CHAR_LOW; c <= CHAR_HIGH; c++) begin
      if (c != CHAR_PLUS && c != CHAR_MINUS) begin
        pool[k] = CHAR_W'(c);
        k++;
      end
    end
    for (int unsigned i = 0; i < rdx; i++) begin
      j = $urandom_range(i, POOL_SIZE - 1);
      tmp = pool[i];
      pool[i] = pool[j];
      pool[j] = tmp;
      alpha_buf[i] = pool[i];
    end
    fill_tail(rdx);
  endfunction

  // Breaks the current alphabet of rdx symbols and returns the radix to use.
  function automatic int unsigned spoil_alphabet(flaw_e flaw, int unsigned rdx);
    int unsigned pos;
    int unsigned other;
    pos = $urandom_range(0, rdx - 1);
    other = (pos + $urandom_range(1, rdx - 1)) % rdx;
    case (flaw)
      BAD_RADIX_LOW:  rdx = $urandom_range(0, RADIX_MIN - 1);
      BAD_RADIX_HIGH: rdx = $urandom_range(MAX_DIGITS + 1, (1 << RADIX_W) - 1);
      BAD_PLUS:       alpha_buf[pos] = CHAR_PLUS;
      BAD_MINUS:      alpha_buf[pos] = CHAR_MINUS;
      BAD_CONTROL:    alpha_buf[pos] = CHAR_W'($urandom_range(0, CHAR_LOW - 1));
      BAD_HIGH_BIT:   alpha_buf[pos] = CHAR_W'($urandom_range(CHAR_HIGH + 1, 255));
      default:        alpha_buf[other] = alpha_buf[pos];
    endcase
    return rdx;
  endfunction

  // Mixture of full-range, small, boundary and radix-power values.
  function automatic logic [NUM_W-1:0] pick_number();
    logic [NUM_W-1:0] v;
    longint unsigned  p;
    int unsigned      k;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2:    v = $urandom_range(0, 40);
      3:    v = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                     : 32'h7FFF_FFFF - $urandom_range(0, 3);
      4: begin
        p = 1;
        k = $urandom_range(1, 31);
        if (cur_radix >= RADIX_MIN && cur_radix <= MAX_DIGITS) begin
          repeat (k) if (p * cur_radix <= 64'h7FFF_FFFF) p = p * cur_radix;
        end
        v = NUM_W'(p - $urandom_range(0, 1));
      end
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 2) == 0) v = -v;
    return v;
  endfunction

  // Leaves the input idle until every spelled character has been taken.
  task automatic wait_idle();
    push <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
  endtask

  // Writes radix and all symbol banks while the block is idle; the spare
  // indexes past the last bank take random data and must change nothing.
  task automatic apply_config(int unsigned rdx, bit with_spare);
    logic [CFG_DATA_W-1:0] word;
    wait_idle();
    word = {$urandom, $urandom};
    if ($urandom_range(0, 1) == 0) word = '0;
    word[RADIX_W-1:0] = RADIX_W'(rdx);
    put_reg(CFG_RADIX, word);
    for (int k = 0; k < NUM_BANKS; k++) begin
      for (int b = 0; b < SYMS_PER_REG; b++)
        word[b*CHAR_W +: CHAR_W] = alpha_buf[k*SYMS_PER_REG + b];
      put_reg(CFG_IDX_W'(CFG_DIGITS_A + k), word);
    end
    if (with_spare || $urandom_range(0, 3) == 0) begin
      for (int k = NUM_BANKS; k < (1 << CFG_IDX_W) - 1; k++)
        put_reg(CFG_IDX_W'(CFG_DIGITS_A + k), {$urandom, $urandom});
    end
    cfg_we <= 1'b0;
    cur_radix = rdx;
  endtask

  // One input transfer, after an optional gap.
  task automatic send_number(logic [NUM_W-1:0] n);
    int unsigned gap;
    gap = idle_len(send_steady);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push   <= 1'b1;
    number <= n;
    do @(posedge clk_i); while (full);
    sent++;
  endtask

  // Stimulus and verdict.
  initial begin
    int unsigned target;
    int unsigned rdx;
    int unsigned pick;
    int unsigned phase_len;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The alphabet out of reset is empty and so invalid.
    send_number(32'd0);
    send_number(32'hFFFF_FFFF);

    // Decimal, with junk past the alphabet.
    load_text("0123456789");
    apply_config(10, 1'b1);
    send_number(32'd0);
    send_number(32'd7);
    send_number(32'd10);
    send_number(32'hFFFF_FFFF);
    send_number(32'h7FFF_FFFF);
    send_number(32'h8000_0000);
    send_number(32'd1_000_000);

    // Binary: the most negative number gives a sign and 32 digits.
    load_text("01");
    apply_config(2, 1'b0);
    send_number(32'h8000_0000);
    send_number(32'h7FFF_FFFF);
    send_number(32'hFFFF_FFFF);

    // Largest alphabet, with the lowest and highest printable symbols.
    load_text(" !\"#$%&'()*,./0123456789:;<=>?@");
    alpha_buf[SYM_SLOTS-1] = CHAR_HIGH;
    apply_config(MAX_DIGITS, 1'b0);
    send_number(32'd31);
    send_number(32'd32);
    send_number(-32'sd33);
    send_number(32'h7FFF_FFFF);

    // Each kind of bad alphabet once.
    for (int f = BAD_RADIX_LOW; f <= BAD_REPEAT; f++) begin
      load_text("0123456789");
      apply_config(spoil_alphabet(flaw_e'(f), 10), 1'b0);
      send_number($urandom);
    end

    // Random alphabets and numbers, mostly valid.
    target = sent + RANDOM_ITEMS;
    while (sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        rdx = (pick < 12) ? RADIX_MIN : (pick < 24) ? MAX_DIGITS
                                                    : $urandom_range(RADIX_MIN, MAX_DIGITS);
        random_alphabet(rdx);
        phase_len = $urandom_range(8, 40);
      end else begin
        rdx = $urandom_range(RADIX_MIN, MAX_DIGITS);
        random_alphabet(rdx);
        rdx = spoil_alphabet(flaw_e'($urandom_range(BAD_RADIX_LOW, BAD_REPEAT)), rdx);
        phase_len = $urandom_range(2, 6);
      end
      apply_config(rdx, 1'b0);
      repeat (phase_len) begin
        // Now and then hold off until every character has drained.
        if ($urandom_range(0, 49) == 0) wait_idle();
        if ($urandom_range(0, 29) == 0) send_steady = !send_steady;
        send_number(pick_number());
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### signed_radix_to_text.f
rtl/srt_pkg.sv
rtl/srt_cfg.sv
rtl/srt_front.sv
rtl/srt_queue.sv
rtl/srt_back.sv
rtl/signed_radix_to_text.sv
tb/signed_radix_to_text_checker.sv
tb/tb_signed_radix_to_text.sv
